/* rtl/core/tte_pkg.sv */
package tte_pkg;

    localparam int MAX_TIMERS = 8;
    localparam int ID_SPACE   = 8;
    localparam int ID_W       = 3;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int DL_W       = 63;
    localparam int NOW_W      = 62;
    localparam int SEC_W      = 32;
    localparam int USEC_W     = 20;
    localparam int PROD_W     = SEC_W + USEC_W;
    localparam int LIVE_W     = 4;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    localparam logic [1:0] FN_ADD     = 2'd0;
    localparam logic [1:0] FN_DELETE  = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;
    localparam logic [1:0] FN_QUERY   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NO_ID   = 2'd2;
    localparam logic [1:0] STAT_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [ID_W-1:0]   target_id;
        logic [SEC_W-1:0]  period_seconds;
        logic [USEC_W-1:0] period_micros;
        logic [NOW_W-1:0]  now_us;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   assigned_id;
        logic              next_valid;
        logic [ID_W-1:0]   next_id;
        logic [DL_W-1:0]   next_deadline;
        logic [LIVE_W-1:0] live_timers;
    } t_result;

    // One table entry as held by a cell
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DL_W-1:0]   deadline;
        logic [SEC_W-1:0]  psec;
        logic [USEC_W-1:0] pusec;
    } t_slot;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] deadline;
    } t_min;

    typedef struct packed {
        logic load;
        logic shift;
        logic rearm;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_APPLY,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* rtl/core/tte_cell.sv */
module tte_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tte_pkg::t_cell_ctl     i_ctl,
    input  tte_pkg::t_slot         i_new,
    input  tte_pkg::t_slot         i_right,
    input  logic [tte_pkg::ID_W-1:0] i_target,
    input  tte_pkg::t_min          i_min,
    output tte_pkg::t_slot         o_slot,
    output logic                   o_match,
    output tte_pkg::t_min          o_min
);
    import tte_pkg::*;

    t_slot r_slot;
    t_min  r_min;
    logic  take_own;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_slot <= i_right;
        end else if (i_ctl.load) begin
            r_slot <= i_new;
        end else if (i_ctl.rearm) begin
            r_slot.deadline <= i_new.deadline;
        end
    end

    // Strict compare keeps the entry nearer the front on a tie
    assign take_own = r_slot.valid && (!i_min.valid || (r_slot.deadline < i_min.deadline));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min.valid <= 1'b0;
        end else if (take_own) begin
            r_min.valid    <= 1'b1;
            r_min.id       <= r_slot.id;
            r_min.deadline <= r_slot.deadline;
        end else begin
            r_min <= i_min;
        end
    end

    assign o_slot  = r_slot;
    assign o_match = r_slot.valid && (r_slot.id == i_target);
    assign o_min   = r_min;

endmodule

/* rtl/core/timer_table_earliest_deadline_unit.sv */
// Channel  | Ports                 | Transfer
// ---------+-----------------------+-------------------------------------
// command  | start, busy, i_cmd    | rising edge with start high, busy low
// result   | o_valid, o_result     | one cycle with o_valid high, no stall
//
// Add and restart pass through S_CHECK, S_MUL, S_APPLY, S_SCAN and S_DONE; delete
// skips S_MUL. In S_SCAN the earliest deadline ripples through the row of cells,
// one cell per cycle. Query and rejected commands go from S_CHECK to S_DONE.
// Reset clears the table at once; a command may follow the cycle after reset.
// busy stays high until the cycle after the result strobe.
module timer_table_earliest_deadline_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tte_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    output tte_pkg::t_result o_result
);
    import tte_pkg::*;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_scan;
    logic [ID_SPACE-1:0]   r_id_used;
    logic [1:0]            r_status;
    logic [ID_W-1:0]       r_assigned;
    t_min                  r_next;
    logic [PROD_W-1:0]     r_prod;
    logic [USEC_W-1:0]     r_usec;

    t_slot                 slots   [MAX_TIMERS];
    t_cell_ctl             ctl     [MAX_TIMERS];
    t_min                  min_in  [MAX_TIMERS];
    t_min                  min_out [MAX_TIMERS];
    t_slot                 right   [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] match;
    logic [MAX_TIMERS-1:0] hit_prefix;
    logic                  any_match;
    logic [ID_W-1:0]       free_id;
    logic                  free_found;
    logic                  full;
    logic [SEC_W-1:0]      sel_psec;
    logic [USEC_W-1:0]     sel_pusec;
    logic [DL_W-1:0]       new_dl;
    t_slot                 new_slot;
    logic [1:0]            chk_status;

    genvar g;
    generate
        for (g = 0; g < MAX_TIMERS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign min_in[g]     = '0;
                assign hit_prefix[g] = match[g];
            end else begin : g_body
                assign min_in[g]     = min_out[g-1];
                assign hit_prefix[g] = hit_prefix[g-1] | match[g];
            end
            if (g == MAX_TIMERS - 1) begin : g_tail
                assign right[g] = '0;
            end else begin : g_mid
                assign right[g] = slots[g+1];
            end

            assign ctl[g].load  = (r_state == S_APPLY) && (r_cmd.func == FN_ADD)
                                  && (r_count == CNT_W'(g));
            assign ctl[g].shift = (r_state == S_APPLY) && (r_cmd.func == FN_DELETE)
                                  && hit_prefix[g];
            assign ctl[g].rearm = (r_state == S_APPLY) && (r_cmd.func == FN_RESTART)
                                  && match[g];

            tte_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (ctl[g]),
                .i_new    (new_slot),
                .i_right  (right[g]),
                .i_target (r_cmd.target_id),
                .i_min    (min_in[g]),
                .o_slot   (slots[g]),
                .o_match  (match[g]),
                .o_min    (min_out[g])
            );
        end
    endgenerate

    assign any_match = |match;

    // Lowest free id
    always_comb begin
        free_id    = '0;
        free_found = 1'b0;
        for (int k = ID_SPACE - 1; k >= 0; k--) begin
            if (!r_id_used[k]) begin
                free_id    = ID_W'(k);
                free_found = 1'b1;
            end
        end
    end

    assign full = (r_count == CNT_W'(MAX_TIMERS)) || !free_found;

    // Period of the matching entry; ids are unique so at most one hits
    always_comb begin
        sel_psec  = '0;
        sel_pusec = '0;
        for (int k = 0; k < MAX_TIMERS; k++) begin
            sel_psec  = sel_psec  | (slots[k].psec  & {SEC_W{match[k]}});
            sel_pusec = sel_pusec | (slots[k].pusec & {USEC_W{match[k]}});
        end
    end

    assign new_dl = {1'b0, r_cmd.now_us} + {{(DL_W - PROD_W){1'b0}}, r_prod}
                    + {{(DL_W - USEC_W){1'b0}}, r_usec};

    always_comb begin
        new_slot.valid    = 1'b1;
        new_slot.id       = r_assigned;
        new_slot.deadline = new_dl;
        new_slot.psec     = r_cmd.period_seconds;
        new_slot.pusec    = r_cmd.period_micros;
    end

    always_comb begin
        unique case (r_cmd.func)
            FN_ADD:     chk_status = full ? STAT_FULL : STAT_OK;
            FN_DELETE,
            FN_RESTART: chk_status = any_match ? STAT_OK : STAT_NO_ID;
            default:    chk_status = (r_count == '0) ? STAT_EMPTY : STAT_OK;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                unique case (r_cmd.func)
                    FN_ADD:     n_state = full ? S_DONE : S_MUL;
                    FN_DELETE:  n_state = any_match ? S_APPLY : S_DONE;
                    FN_RESTART: n_state = any_match ? S_MUL : S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_MUL:   n_state = S_APPLY;
            S_APPLY: n_state = S_SCAN;
            S_SCAN: begin
                if (r_scan == CNT_W'(MAX_TIMERS)) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy    = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
    end

    always_comb begin
        o_result.status        = r_status;
        o_result.assigned_id   = r_assigned;
        o_result.next_valid    = r_next.valid;
        o_result.next_id       = r_next.valid ? r_next.id : '0;
        o_result.next_deadline = r_next.valid ? r_next.deadline : '0;
        o_result.live_timers   = LIVE_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_id_used    <= '0;
            r_scan       <= '0;
            r_next.valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) r_cmd <= i_cmd;
                end
                S_CHECK: begin
                    r_status   <= chk_status;
                    r_assigned <= ((r_cmd.func == FN_ADD) && !full) ? free_id : '0;
                end
                S_MUL: begin
                    if (r_cmd.func == FN_ADD) begin
                        r_prod <= PROD_W'(r_cmd.period_seconds) * PROD_W'(USEC_PER_SEC);
                        r_usec <= r_cmd.period_micros;
                    end else begin
                        r_prod <= PROD_W'(sel_psec) * PROD_W'(USEC_PER_SEC);
                        r_usec <= sel_pusec;
                    end
                end
                S_APPLY: begin
                    r_scan <= '0;
                    if (r_cmd.func == FN_ADD) begin
                        r_count               <= r_count + 1'b1;
                        r_id_used[r_assigned] <= 1'b1;
                    end else if (r_cmd.func == FN_DELETE) begin
                        r_count                    <= r_count - 1'b1;
                        r_id_used[r_cmd.target_id] <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    // hold the result once the minimum has reached the last cell
                    if (r_scan == CNT_W'(MAX_TIMERS)) r_next <= min_out[MAX_TIMERS-1];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* verif/tte_checker.sv */
`timescale 1ns / 1ps

module tte_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  tte_pkg::t_cmd        cmd,
    input  logic                 o_valid,
    input  tte_pkg::t_result     result,
    output int                   mismatches,
    output int                   outstanding,
    output int                   checked,
    output int                   full_hits,
    output int                   no_id_hits,
    output int                   empty_hits
);
    import tte_pkg::*;

    // Shadow of the timer table, compacted in insertion order
    logic [ID_W-1:0]   tab_id   [MAX_TIMERS];
    logic [DL_W-1:0]   tab_dl   [MAX_TIMERS];
    logic [SEC_W-1:0]  tab_sec  [MAX_TIMERS];
    logic [USEC_W-1:0] tab_usec [MAX_TIMERS];
    bit                id_taken [ID_SPACE];
    int                live;
    int                first_slot;

    t_result           due_results[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        full_hits   = 0;
        no_id_hits  = 0;
        empty_hits  = 0;
    end

    function automatic logic [DL_W-1:0] due_at(input logic [NOW_W-1:0] now,
                                              input logic [SEC_W-1:0] sec,
                                              input logic [USEC_W-1:0] usec);
        logic [63:0] sum;
        sum = 64'(now) + 64'(sec) * 64'(USEC_PER_SEC) + 64'(usec);
        return sum[DL_W-1:0];
    endfunction

    // Tie goes to the entry nearer the front
    function automatic void rescan();
        int i;
        first_slot = 0;
        for (i = 1; i < live; i++)
            if (tab_dl[i] < tab_dl[first_slot])
                first_slot = i;
    endfunction

    function automatic int slot_of(input logic [ID_W-1:0] id);
        int i;
        if (!id_taken[id])
            return -1;
        for (i = 0; i < live; i++)
            if (tab_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic t_result apply_cmd(input t_cmd c);
        t_result r;
        int      s;
        int      free_id;
        int      i;
        r = '0;
        r.status = STAT_OK;
        if (c.func == FN_ADD) begin
            free_id = -1;
            for (i = ID_SPACE - 1; i >= 0; i--)
                if (!id_taken[i])
                    free_id = i;
            if (live >= MAX_TIMERS || free_id < 0) begin
                r.status = STAT_FULL;
            end else begin
                tab_id[live]   = ID_W'(free_id);
                tab_sec[live]  = c.period_seconds;
                tab_usec[live] = c.period_micros;
                tab_dl[live]   = due_at(c.now_us, c.period_seconds, c.period_micros);
                id_taken[free_id] = 1'b1;
                live++;
                r.assigned_id = ID_W'(free_id);
                rescan();
            end
        end else if (c.func == FN_DELETE) begin
            s = slot_of(c.target_id);
            if (s < 0) begin
                r.status = STAT_NO_ID;
            end else begin
                // close the gap
                for (i = s; i < live - 1; i++) begin
                    tab_id[i]   = tab_id[i+1];
                    tab_dl[i]   = tab_dl[i+1];
                    tab_sec[i]  = tab_sec[i+1];
                    tab_usec[i] = tab_usec[i+1];
                end
                id_taken[c.target_id] = 1'b0;
                live--;
                rescan();
            end
        end else if (c.func == FN_RESTART) begin
            s = slot_of(c.target_id);
            if (s < 0) begin
                r.status = STAT_NO_ID;
            end else begin
                tab_dl[s] = due_at(c.now_us, tab_sec[s], tab_usec[s]);
                rescan();
            end
        end else if (live == 0) begin
            r.status = STAT_EMPTY;
        end
        if (live > 0) begin
            r.next_valid    = 1'b1;
            r.next_id       = tab_id[first_slot];
            r.next_deadline = tab_dl[first_slot];
        end
        r.live_timers = LIVE_W'(live);
        return r;
    endfunction

    function automatic void report(input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  exp: st=%0d aid=%0d nv=%0d nid=%0d dl=%0h live=%0d",
                     want.status, want.assigned_id, want.next_valid, want.next_id,
                     want.next_deadline, want.live_timers);
            $display("  got: st=%0d aid=%0d nv=%0d nid=%0d dl=%0h live=%0d",
                     got.status, got.assigned_id, got.next_valid, got.next_id,
                     got.next_deadline, got.live_timers);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            for (int k = 0; k < ID_SPACE; k++)
                id_taken[k] = 1'b0;
            live       = 0;
            first_slot = 0;
            due_results.delete();
        end else begin
            if (o_valid) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result strobe with no command waiting", $realtime);
                end else begin
                    want = due_results.pop_front();
                    checked++;
                    bad = 1'b0;
                    if (result.status        !== want.status)        bad = 1'b1;
                    if (result.assigned_id   !== want.assigned_id)   bad = 1'b1;
                    if (result.next_valid    !== want.next_valid)    bad = 1'b1;
                    if (result.next_id       !== want.next_id)       bad = 1'b1;
                    if (result.next_deadline !== want.next_deadline) bad = 1'b1;
                    if (result.live_timers   !== want.live_timers)   bad = 1'b1;
                    if (bad)
                        report(want, result);
                end
            end
            if (start && !busy) begin
                want = apply_cmd(cmd);
                case (want.status)
                    STAT_FULL:  full_hits++;
                    STAT_NO_ID: no_id_hits++;
                    STAT_EMPTY: empty_hits++;
                    default: ;
                endcase
                due_results.push_back(want);
            end
        end
        outstanding = due_results.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tte_pkg::*;

    localparam int RANDOM_CMDS = 1950;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    cmd;
    logic    o_valid;
    t_result o_result;

    int      mismatches;
    int      outstanding;
    int      checked;
    int      full_hits;
    int      no_id_hits;
    int      empty_hits;
    int      cycles = 0;

    timer_table_earliest_deadline_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    tte_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .o_valid     (o_valid),
        .result      (o_result),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .full_hits   (full_hits),
        .no_id_hits  (no_id_hits),
        .empty_hits  (empty_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("** timer_table_earliest_deadline_unit: FAILED **");
            $finish;
        end
    end

    function automatic t_cmd timer_cmd(input logic [1:0] fn, input logic [ID_W-1:0] id,
                                       input logic [SEC_W-1:0] sec,
                                       input logic [USEC_W-1:0] usec,
                                       input logic [NOW_W-1:0] now);
        t_cmd c;
        c.func           = fn;
        c.target_id      = id;
        c.period_seconds = sec;
        c.period_micros  = usec;
        c.now_us         = now;
        return c;
    endfunction

    function automatic t_cmd junk_cmd();
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        return w[$bits(t_cmd)-1:0];
    endfunction

    // Small values make deadline ties common; wide ones toggle every bit
    function automatic t_cmd random_cmd(input int add_pct);
        t_cmd        c;
        logic [63:0] w;
        int          pick;
        c = junk_cmd();
        pick = $urandom_range(99);
        if (pick < add_pct) begin
            c.func = FN_ADD;
        end else begin
            pick = $urandom_range(99);
            if (pick < 35)      c.func = FN_DELETE;
            else if (pick < 75) c.func = FN_RESTART;
            else                c.func = FN_QUERY;
        end
        c.target_id = ID_W'($urandom_range(ID_SPACE - 1));
        pick = $urandom_range(9);
        if (pick < 4)       c.period_seconds = SEC_W'($urandom_range(3));
        else if (pick < 7)  c.period_seconds = SEC_W'($urandom_range(1000));
        else if (pick < 9)  c.period_seconds = SEC_W'($urandom);
        else                c.period_seconds = '1;
        pick = $urandom_range(9);
        if (pick < 4)       c.period_micros = USEC_W'($urandom_range(3));
        else if (pick < 8)  c.period_micros = USEC_W'($urandom_range(999999));
        else if (pick < 9)  c.period_micros = USEC_W'($urandom_range(20'hFFFFF, 1000000));
        else                c.period_micros = '1;
        w = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick < 4)       c.now_us = NOW_W'($urandom_range(7));
        else if (pick < 6)  c.now_us = NOW_W'($urandom);
        else if (pick < 9)  c.now_us = w[NOW_W-1:0];
        else                c.now_us = '1;
        return c;
    endfunction

    // Hold start until the command transfers; idle first now and then
    task automatic issue(input t_cmd c, input bit may_idle);
        int gap;
        gap = (may_idle && $urandom_range(99) < 8) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            cmd   = junk_cmd();
            // idle while the block is free, not while it is still working
            while (busy)
                @(negedge i_clk);
            repeat (gap) begin
                @(negedge i_clk);
                cmd = junk_cmd();
            end
        end
        start = 1'b1;
        cmd   = c;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_cmd directed[$];
        int   add_pct;
        start   = 1'b0;
        cmd     = junk_cmd();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: query, delete and restart all rejected
        directed.push_back(timer_cmd(FN_QUERY,   3'd0, '0, '0, '0));
        directed.push_back(timer_cmd(FN_DELETE,  3'd5, '0, '0, '0));
        directed.push_back(timer_cmd(FN_RESTART, 3'd2, '0, '0, '0));
        // widest deadline, then zero deadline, then six equal deadlines
        directed.push_back(timer_cmd(FN_ADD, 3'd7, '1, '1, '1));
        directed.push_back(timer_cmd(FN_ADD, 3'd0, '0, '0, '0));
        repeat (6)
            directed.push_back(timer_cmd(FN_ADD, 3'd0, '0, 20'd100, '0));
        directed.push_back(timer_cmd(FN_ADD,     3'd0, 32'd1, 20'd1, 62'd1));
        directed.push_back(timer_cmd(FN_QUERY,   3'd0, '0, '0, '0));
        directed.push_back(timer_cmd(FN_RESTART, 3'd1, '0, '0, 62'd5));
        // drop the earliest: tie among equal deadlines
        directed.push_back(timer_cmd(FN_DELETE,  3'd1, '0, '0, '0));
        directed.push_back(timer_cmd(FN_RESTART, 3'd4, '0, '0, '0));
        directed.push_back(timer_cmd(FN_DELETE,  3'd0, '0, '0, '0));
        // lowest free id is reused; equal deadline later in the table loses
        directed.push_back(timer_cmd(FN_ADD,     3'd6, '0, 20'd50, 62'd50));
        directed.push_back(timer_cmd(FN_DELETE,  3'd7, '0, '0, '0));
        directed.push_back(timer_cmd(FN_RESTART, 3'd7, '1, '1, '1));
        directed.push_back(timer_cmd(FN_RESTART, 3'd1, '0, '0, '0));
        directed.push_back(timer_cmd(FN_ADD,     3'd0, '0, 20'hFFFFF, 62'd3));
        directed.push_back(timer_cmd(FN_QUERY,   3'd0, '0, '0, '0));
        foreach (directed[k])
            issue(directed[k], 1'b1);

        // swing between filling and draining so full and empty recur
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            add_pct = ((n / 120) % 2 == 0) ? 55 : 15;
            issue(random_cmd(add_pct), !(n >= 700 && n < 1100));
        end
        @(negedge i_clk);
        start = 1'b0;
        cmd   = junk_cmd();

        while (outstanding != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("checked %0d results over %0d commands in %0d cycles",
                 checked, directed.size() + RANDOM_CMDS, cycles);
        $display("rejections seen: table full %0d, unknown id %0d, empty query %0d",
                 full_hits, no_id_hits, empty_hits);
        if (mismatches == 0) begin
            $display("** timer_table_earliest_deadline_unit: PASSED **");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("** timer_table_earliest_deadline_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tte_pkg.sv
rtl/core/tte_cell.sv
rtl/core/timer_table_earliest_deadline_unit.sv
verif/tte_checker.sv
verif/tb_top.sv
